@@ sv/bpz_pkg.sv @@
`timescale 1ns / 1ps

package bpz_pkg;

   // Field widths of the request and the staged bit stream
   localparam int PayloadWidth = 64;
   localparam int CountWidth   = 7;
   localparam int StreamWidth  = PayloadWidth + 1;
   localparam int LenWidth     = 7;
   localparam int FillWidth    = 3;
   localparam int ByteWidth    = 8;

   // Request actions
   typedef enum logic [1:0] {
      ACT_BIT   = 2'd0,
      ACT_RAW   = 2'd1,
      ACT_COMP  = 2'd2,
      ACT_FLUSH = 2'd3
   } action_type;

   // Result of one pass through the byte merge unit
   typedef struct packed {
      logic [ByteWidth-1:0] byte_val;
      logic                 full;
      logic                 last;
      logic [3:0]           take;
      logic [LenWidth-1:0]  rem_next;
      logic [FillWidth-1:0] fill_next;
   } merge_type;

endpackage

@@ sv/bpz_stream_fmt.sv @@
`timescale 1ns / 1ps

module bpz_stream_fmt (
   input  logic [1:0]                     action,
   input  logic [bpz_pkg::PayloadWidth-1:0] payload,
   input  logic [bpz_pkg::CountWidth-1:0]   bit_count,
   input  logic [bpz_pkg::FillWidth-1:0]    fill,
   output logic [bpz_pkg::StreamWidth-1:0]  stream,
   output logic [bpz_pkg::LenWidth-1:0]     len
);
   import bpz_pkg::*;

   logic [3:0]              nbytes;
   logic [LenWidth-1:0]     bits;
   logic [5:0]              sh;
   logic [PayloadWidth-1:0] data;
   logic [2:0]              zc;
   logic                    found;
   logic                    top_case;
   logic                    nibble;
   logic [PayloadWidth-1:0] body;
   logic [StreamWidth-1:0]  tmp;
   logic [StreamWidth-1:0]  mask;
   logic [3:0]              used_bytes;
   logic [LenWidth-1:0]     comp_len;

   // Size the field in bits, saturated
   always_comb begin
      nbytes = bit_count[6] ? 4'd8 : {1'b0, bit_count[5:3]};
      case (action_type'(action))
         ACT_BIT:  bits = 7'd1;
         ACT_RAW:  bits = (bit_count > 7'd64) ? 7'd64 : bit_count;
         ACT_COMP: bits = {nbytes, 3'b000};
         default:  bits = '0;
      endcase
   end

   // Left-align the used payload bits
   assign sh   = 6'(7'd64 - bits);
   assign data = payload << sh;

   // Count trailing zero bytes below the top byte
   always_comb begin
      found = 1'b0;
      zc    = '0;
      for (int j = 0; j < 7; j++) begin
         if (!found && ((4'(j) + 4'd1) < nbytes)) begin
            if (payload[8*j +: 8] != 8'h00) begin
               found = 1'b1;
            end else begin
               zc = zc + 3'd1;
            end
         end
      end
   end

   // Build marker bits and body of a compressed value
   always_comb begin
      top_case   = (({1'b0, zc} + 4'd1) == nbytes);
      nibble     = top_case && (data[63:60] == 4'h0);
      body       = nibble ? (data << 4) : data;
      tmp        = {nibble, body} >> zc;
      mask       = ~({StreamWidth{1'b1}} >> zc);
      used_bytes = nbytes - {1'b0, zc};
      if (nbytes == 4'd0) begin
         comp_len = '0;
      end else if (nibble) begin
         comp_len = {4'b0000, zc} + 7'd5;
      end else begin
         comp_len = {4'b0000, zc} + 7'd1 + {used_bytes, 3'b000};
      end
   end

   // Select the staged stream for the action
   always_comb begin
      case (action_type'(action))
         ACT_BIT, ACT_RAW: begin
            stream = {data, 1'b0};
            len    = bits;
         end
         ACT_COMP: begin
            stream = tmp | mask;
            len    = comp_len;
         end
         default: begin
            // pad the partial byte with zero bits
            stream = '0;
            len    = (fill != '0) ? 7'(4'd8 - {1'b0, fill}) : '0;
         end
      endcase
   end

endmodule

@@ sv/bpz_byte_merge.sv @@
`timescale 1ns / 1ps

module bpz_byte_merge (
   input  logic [bpz_pkg::ByteWidth-1:0] partial,
   input  logic [bpz_pkg::FillWidth-1:0] fill,
   input  logic [bpz_pkg::ByteWidth-1:0] head,
   input  logic [bpz_pkg::LenWidth-1:0]  rem,
   output bpz_pkg::merge_type            mrg
);
   import bpz_pkg::*;

   logic [3:0] room;
   logic [3:0] take;
   logic [3:0] fill_sum;
   logic [LenWidth-1:0] rem_next;

   // Take as many stream bits as fit in the partial byte
   always_comb begin
      room     = 4'd8 - {1'b0, fill};
      take     = (rem < {3'b000, room}) ? rem[3:0] : room;
      fill_sum = {1'b0, fill} + take;
      rem_next = rem - {3'b000, take};

      mrg.byte_val  = partial | (head >> fill);
      mrg.full      = fill_sum[3];
      mrg.last      = fill_sum[3] && (rem_next < 7'd8);
      mrg.take      = take;
      mrg.rem_next  = rem_next;
      mrg.fill_next = fill_sum[2:0];
   end

endmodule

@@ sv/bit_packer_with_zero_byte_elision_top.sv @@
`timescale 1ns / 1ps
// A request is staged as a left-aligned bit stream at acceptance; its first byte, if any,
// passes from the staged stream through the byte merge unit into the rsp_ register once it is free.
// Throughput: the byte merge unit takes up to 8 stream bits a cycle while the result register is free;
// a new request is accepted only once the last one's stream bits are all merged, at once if it has none.
// Reset (synchronous) clears the partial byte, its fill count, the remaining bit count, the sequencer and rsp_valid.
module bit_packer_with_zero_byte_elision_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_action,
   input  logic [bpz_pkg::PayloadWidth-1:0] req_payload,
   input  logic [bpz_pkg::CountWidth-1:0]   req_bit_count,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bpz_pkg::ByteWidth-1:0]    rsp_packed_byte,
   output logic                             rsp_last_of_run
);
   import bpz_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type              state_ff, state_in;
   logic [StreamWidth-1:0] stream_ff, stream_in;
   logic [LenWidth-1:0]    rem_ff, rem_in;
   logic [ByteWidth-1:0]   partial_ff, partial_in;
   logic [FillWidth-1:0]   fill_ff, fill_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ByteWidth-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [StreamWidth-1:0] fmt_stream;
   logic [LenWidth-1:0]    fmt_len;
   merge_type              mrg;
   logic                   accept;
   logic                   step;

   bpz_stream_fmt u_fmt (
      .action    (req_action),
      .payload   (req_payload),
      .bit_count (req_bit_count),
      .fill      (fill_ff),
      .stream    (fmt_stream),
      .len       (fmt_len)
   );

   bpz_byte_merge u_merge (
      .partial (partial_ff),
      .fill    (fill_ff),
      .head    (stream_ff[StreamWidth-1 -: ByteWidth]),
      .rem     (rem_ff),
      .mrg     (mrg)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign step      = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_ready);

   // Sequence loading, merging and output staging
   always_comb begin
      state_in     = state_ff;
      stream_in    = stream_ff;
      rem_in       = rem_ff;
      partial_in   = partial_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               stream_in = fmt_stream;
               rem_in    = fmt_len;
               if (fmt_len != '0) begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (step) begin
               stream_in  = stream_ff << mrg.take;
               rem_in     = mrg.rem_next;
               fill_in    = mrg.fill_next;
               partial_in = mrg.full ? '0 : mrg.byte_val;
               if (mrg.full) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = mrg.byte_val;
                  rsp_last_in  = mrg.last;
               end
               if (mrg.rem_next == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rem_ff       <= '0;
         partial_ff   <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rem_ff       <= rem_in;
         partial_ff   <= partial_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stream_ff   <= stream_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packed_byte = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

@@ sv/bpz_checker.sv @@
`timescale 1ns / 1ps

module bpz_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_action,
   input logic [6:0] req_bit_count,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_packed_byte,
   input logic       rsp_last_of_run
);
   import bpz_pkg::*;

   // Drop any pending byte on reset
   a_reset_clears : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // Hold a stalled response
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_packed_byte)
                                  && $stable(rsp_last_of_run))
      else $error("stalled response changed");

   // Busy after a raw request with a full byte of bits
   a_raw_busy : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ACT_RAW) && (req_bit_count >= 7'd8)
      |=> !req_ready)
      else $error("ready straight after a raw request");

   // Busy after a compressed request of at least one byte
   a_comp_busy : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ACT_COMP) && (req_bit_count >= 7'd8)
      |=> !req_ready)
      else $error("ready straight after a compressed request");

endmodule

bind bit_packer_with_zero_byte_elision_top bpz_checker u_bpz_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_action      (req_action),
   .req_bit_count   (req_bit_count),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_packed_byte (rsp_packed_byte),
   .rsp_last_of_run (rsp_last_of_run)
);
